[src/atilt_pkg.sv]
// Shared constants, types and arctangent table for the accelerometer tilt block.
package atilt_pkg;

  localparam int STEPS_DEF = 16;
  localparam int TAB_LEN   = 24;
  localparam int IN_W      = 16;
  localparam int TILT_W    = 15;
  localparam int SQ_W      = 48;
  localparam int ROOT_W    = 24;
  localparam int REM_W     = 25;
  localparam int XY_W      = 27;
  localparam int Z_W       = 32;
  localparam int FRAC      = 16;
  localparam logic signed [TILT_W-1:0] ANGLE_MAX = 15'sd9000;

  // atan(2^-i) in hundredths of a degree, Q16
  localparam logic [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
    32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507, 32'd23437865,
    32'd11730358, 32'd5866610, 32'd2933484, 32'd1466764, 32'd733385,
    32'd366693, 32'd183346, 32'd91673, 32'd45837, 32'd22918, 32'd11459,
    32'd5730, 32'd2865, 32'd1432, 32'd716, 32'd358, 32'd179, 32'd90, 32'd45
  };

  typedef struct packed {
    logic a_zero;
    logic bc_zero;
    logic neg;
  } side_t;

endpackage

[src/atilt_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module atilt_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [atilt_pkg::SQ_W-1:0]  n,
  input  logic signed [atilt_pkg::IN_W-1:0] a_in,
  input  atilt_pkg::side_t            side_in,
  output logic [atilt_pkg::ROOT_W-1:0] root,
  output logic signed [atilt_pkg::IN_W-1:0] a_out,
  output atilt_pkg::side_t            side_out
);
  localparam int NS = atilt_pkg::ROOT_W;

  logic [atilt_pkg::SQ_W-1:0]   nsh  [NS+1];
  logic [atilt_pkg::REM_W-1:0]  rem  [NS+1];
  logic [atilt_pkg::ROOT_W-1:0] rt   [NS+1];
  logic signed [atilt_pkg::IN_W-1:0] av [NS+1];
  atilt_pkg::side_t             sd   [NS+1];

  assign nsh[0] = n;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign av[0]  = a_in;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [atilt_pkg::REM_W+1:0] remc, trial;
    assign remc  = {rem[k], nsh[k][atilt_pkg::SQ_W-1 -: 2]};
    assign trial = {1'b0, rt[k], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        nsh[k+1] <= {nsh[k][atilt_pkg::SQ_W-3:0], 2'b00};
        av[k+1]  <= av[k];
        sd[k+1]  <= sd[k];
        if (remc >= trial) begin
          rem[k+1] <= atilt_pkg::REM_W'(remc - trial);
          rt[k+1]  <= {rt[k][atilt_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem[k+1] <= atilt_pkg::REM_W'(remc);
          rt[k+1]  <= {rt[k][atilt_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root     = rt[NS];
  assign a_out    = av[NS];
  assign side_out = sd[NS];
endmodule

[src/atilt_cordic.sv]
// Pipelined vectoring CORDIC, one rotation per stage.
module atilt_cordic #(
  parameter int CORDIC_STEPS = atilt_pkg::STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [atilt_pkg::XY_W-1:0] x_in,
  input  logic signed [atilt_pkg::XY_W-1:0] y_in,
  input  atilt_pkg::side_t                  side_in,
  output logic signed [atilt_pkg::Z_W-1:0]  z_out,
  output atilt_pkg::side_t                  side_out
);
  localparam int NS = (CORDIC_STEPS > atilt_pkg::TAB_LEN) ? atilt_pkg::TAB_LEN : CORDIC_STEPS;

  logic signed [atilt_pkg::XY_W-1:0] x [NS+1];
  logic signed [atilt_pkg::XY_W-1:0] y [NS+1];
  logic signed [atilt_pkg::Z_W-1:0]  z [NS+1];
  atilt_pkg::side_t                  sd [NS+1];

  assign x[0]  = x_in;
  assign y[0]  = y_in;
  assign z[0]  = '0;
  assign sd[0] = side_in;

  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + signed'(atilt_pkg::ATAN_TAB[i]);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - signed'(atilt_pkg::ATAN_TAB[i]);
        end
      end
    end
  end

  assign z_out    = z[NS];
  assign side_out = sd[NS];
endmodule

[src/atilt_lane.sv]
// One axis lane: sum of squares, square root, CORDIC, round and clamp.
module atilt_lane #(
  parameter int CORDIC_STEPS = atilt_pkg::STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [atilt_pkg::IN_W-1:0]   a,
  input  logic signed [atilt_pkg::IN_W-1:0]   b,
  input  logic signed [atilt_pkg::IN_W-1:0]   c,
  output logic signed [atilt_pkg::TILT_W-1:0] tilt
);
  logic signed [31:0] bb, cc;
  logic [31:0] sq;
  logic signed [atilt_pkg::IN_W-1:0] a_q;
  atilt_pkg::side_t side_q, side_s, side_c;
  logic [atilt_pkg::ROOT_W-1:0] root;
  logic signed [atilt_pkg::IN_W-1:0] a_s;
  logic signed [atilt_pkg::XY_W-1:0] x0, y0;
  logic signed [atilt_pkg::Z_W-1:0] z, zr;
  logic signed [atilt_pkg::Z_W-atilt_pkg::FRAC-1:0] q;

  // full-width signed squares, each at most 2^30
  assign bb = b * b;
  assign cc = c * c;

  always_ff @(posedge clk) begin
    if (en) begin
      sq  <= unsigned'(bb) + unsigned'(cc);
      a_q <= a;
      side_q.a_zero  <= (a == '0);
      side_q.bc_zero <= (b == '0) && (c == '0);
      side_q.neg     <= a[atilt_pkg::IN_W-1];
    end
  end

  atilt_sqrt u_sqrt (
    .clk(clk), .en(en), .n({sq, 16'h0000}), .a_in(a_q), .side_in(side_q),
    .root(root), .a_out(a_s), .side_out(side_s)
  );

  assign x0 = signed'({3'b000, root});
  assign y0 = signed'({{3{a_s[atilt_pkg::IN_W-1]}}, a_s, 8'h00});

  atilt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .en(en), .x_in(x0), .y_in(y0), .side_in(side_s),
    .z_out(z), .side_out(side_c)
  );

  // round half up, then clamp
  assign zr = z + 32'sd32768;
  assign q  = zr[atilt_pkg::Z_W-1:atilt_pkg::FRAC];

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_c.a_zero)
        tilt <= '0;
      else if (side_c.bc_zero)
        tilt <= side_c.neg ? -atilt_pkg::ANGLE_MAX : atilt_pkg::ANGLE_MAX;
      else if (q > 16'sd9000)
        tilt <= atilt_pkg::ANGLE_MAX;
      else if (q < -16'sd9000)
        tilt <= -atilt_pkg::ANGLE_MAX;
      else
        tilt <= q[atilt_pkg::TILT_W-1:0];
    end
  end
endmodule

[src/accel_tilt_angles.sv]
// Top level: three tilt lanes in parallel and the merged output register.
//
//  channel  dir  beat payload
//  s_*      in   tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32]
//  m_*      out  tdata: tilt_x[14:0], tilt_y[29:15], tilt_z[44:30], zero pad
//                tuser: all_zero
//
// One sample per cycle while the output is not stalled; every pipeline stage advances together.
// Pipeline stages in order: one for squares, 24 for the square root (one bit
// each), one per CORDIC rotation, round/clamp, merge.
// A stall on m_tready holds the whole pipeline; s_tready drops with it.
// Reset clears only the valid bits.
module accel_tilt_angles #(
  parameter int CORDIC_STEPS = atilt_pkg::STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // tilt_x, tilt_y, tilt_z, pad
  output logic        m_tuser    // all_zero
);
  localparam int NS  = (CORDIC_STEPS > atilt_pkg::TAB_LEN) ? atilt_pkg::TAB_LEN : CORDIC_STEPS;
  localparam int LAT = 2 + atilt_pkg::ROOT_W + NS + 1;

  logic en;
  logic [LAT-1:0] vld;
  logic [LAT-2:0] zero_d;
  logic signed [15:0] ax, ay, az;
  logic signed [atilt_pkg::TILT_W-1:0] tx, ty, tz;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign ax = signed'(s_tdata[15:0]);
  assign ay = signed'(s_tdata[31:16]);
  assign az = signed'(s_tdata[47:32]);

  atilt_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
    .clk(clk), .en(en), .a(ax), .b(ay), .c(az), .tilt(tx));
  atilt_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
    .clk(clk), .en(en), .a(ay), .b(ax), .c(az), .tilt(ty));
  atilt_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
    .clk(clk), .en(en), .a(az), .b(ax), .c(ay), .tilt(tz));

  // advance valid bits with the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_d <= {zero_d[LAT-3:0], (s_tdata == '0)};
    end
  end

  // merge stage: pack the lane angles and the all-zero flag
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {3'b000, tz, ty, tx};
      m_tuser <= zero_d[LAT-2];
    end
  end

  assign m_tvalid = vld[LAT-1];

`ifndef NO_ASSERTIONS
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("all_zero beat with nonzero angle");
  a_range_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> signed'(m_tdata[14:0]) <= 15'sd9000 && signed'(m_tdata[14:0]) >= -15'sd9000)
    else $error("tilt_x out of range");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");
`endif
endmodule
